// File: design/psc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

	localparam int DataW = 32;
	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_AC1_AC2 = 3'd0,
		CFG_AC3_AC4 = 3'd1,
		CFG_AC5_AC6 = 3'd2,
		CFG_B1_B2   = 3'd3,
		CFG_MC_MD   = 3'd4,
		CFG_OSS     = 3'd5
	} cfg_idx_t;

	localparam logic [1:0]  OssReset  = 2'd1;
	localparam logic [31:0] B6Offset  = 32'd4000;
	localparam logic [31:0] B4Bias    = 32'd32768;
	localparam logic [31:0] B7Scale   = 32'd50000;
	localparam logic [31:0] PolyC2    = 32'd3038;
	localparam logic [31:0] PolyC1    = 32'hFFFF_E343; // -7357
	localparam logic [31:0] PolyC0    = 32'd3791;
	localparam logic [31:0] SignBit   = 32'h8000_0000;

	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [18:0] raw_pressure;
	} psc_in_t;

	typedef struct packed {
		logic signed [31:0] pressure_pa;
		logic               status;
	} psc_out_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage
`default_nettype wire

// File: design/psc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface psc_in_if;
	import psc_pkg::*;
	logic    valid;
	logic    ready;
	psc_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/psc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface psc_out_if;
	import psc_pkg::*;
	logic     valid;
	logic     ready;
	psc_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/psc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module psc_div #(
	parameter int W  = 32,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_v,
	input  wire logic [W-1:0]  num,
	input  wire logic [W-1:0]  den,
	input  wire logic [SW-1:0] side_in,
	output logic               out_v,
	output logic [W-1:0]       quot,
	output logic [SW-1:0]      side_out
);
	// one quotient bit per stage, restoring
	for (genvar i = 0; i < W; i++) begin : g_step
		logic          v_q;
		logic [W-1:0]  n_q, d_q, r_q;
		logic [SW-1:0] s_q;
		logic          pv;
		logic [W-1:0]  pn, pd, pr;
		logic [SW-1:0] ps;
		logic [W:0]    trial;
		logic [W:0]    diff;
		logic          ge;

		if (i == 0) begin : g_head
			assign pv = in_v;
			assign pn = num;
			assign pd = den;
			assign pr = '0;
			assign ps = side_in;
		end else begin : g_link
			assign pv = g_step[i-1].v_q;
			assign pn = g_step[i-1].n_q;
			assign pd = g_step[i-1].d_q;
			assign pr = g_step[i-1].r_q;
			assign ps = g_step[i-1].s_q;
		end

		assign trial = {pr, pn[W-1]};
		assign diff  = trial - {1'b0, pd};
		assign ge    = trial >= {1'b0, pd};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else if (en) begin
				v_q <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_q <= ge ? diff[W-1:0] : trial[W-1:0];
				n_q <= {pn[W-2:0], ge};
				d_q <= pd;
				s_q <= ps;
			end
		end
	end

	assign out_v    = g_step[W-1].v_q;
	assign quot     = g_step[W-1].n_q;
	assign side_out = g_step[W-1].s_q;

`ifndef SYNTH
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(g_step[W-1].v_q && g_step[W-1].d_q != '0) |-> (g_step[W-1].r_q < g_step[W-1].d_q))
		else $error("divider remainder not below divisor");
	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(en && in_v) |=> g_step[0].v_q)
		else $error("divider lost an item at entry");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(g_step[W-1].v_q))
		else $error("divider moved while stalled");
`endif
endmodule
`default_nettype wire

// File: design/psc_skid.sv
`timescale 1ns / 1ps
`default_nettype none
module psc_skid (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               up_v,
	input  wire psc_pkg::psc_out_t  up_d,
	output logic                    up_ready,
	psc_out_if.source               result
);
	import psc_pkg::*;

	logic     o_v_q, s_v_q;
	psc_out_t o_d_q, s_d_q;

	assign up_ready     = !s_v_q;
	assign result.valid = o_v_q;
	assign result.data  = o_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
			s_v_q <= 1'b0;
		end else if (result.ready || !o_v_q) begin
			if (s_v_q) begin
				o_v_q <= 1'b1;
				s_v_q <= 1'b0;
			end else begin
				o_v_q <= up_v;
			end
		end else if (up_v && !s_v_q) begin
			s_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (result.ready || !o_v_q) begin
			o_d_q <= s_v_q ? s_d_q : up_d;
		end else if (up_v && !s_v_q) begin
			s_d_q <= up_d;
		end
	end

`ifndef SYNTH
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_v_q |-> o_v_q)
		else $error("skid holds an item while output is empty");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s_v_q && !result.ready) |=> s_v_q)
		else $error("skid item dropped");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(o_v_q && o_d_q.status) |-> (o_d_q.pressure_pa == '0))
		else $error("error result carries a pressure");
`endif
endmodule
`default_nettype wire

// File: design/pressure_sensor_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// Result path: an accepted item loads stage 1, then passes two 32-stage
// bit-per-stage dividers and nine arithmetic and output register stages
// before result valid.
// Throughput: one item per cycle; a full output skid stage stalls the pipe.
// Reset: arst_n clears all valid bits and the coefficient registers,
// oversampling resets to 1.
module pressure_sensor_compensation (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [psc_pkg::CfgIdxW-1:0] cfg_idx,
	input  wire logic [psc_pkg::DataW-1:0]   cfg_data,
	psc_in_if.sink                           sample,
	psc_out_if.source                        result
);
	import psc_pkg::*;

	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0]  oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0;
			ac34_q <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
			oss_q  <= OssReset;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_AC1_AC2: ac12_q <= cfg_data;
				CFG_AC3_AC4: ac34_q <= cfg_data;
				CFG_AC5_AC6: ac56_q <= cfg_data;
				CFG_B1_B2:   b12_q  <= cfg_data;
				CFG_MC_MD:   mcmd_q <= cfg_data;
				CFG_OSS:     oss_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sx16(ac12_q[31:16]);
	assign ac2 = sx16(ac12_q[15:0]);
	assign ac3 = sx16(ac34_q[31:16]);
	assign ac4 = {16'd0, ac34_q[15:0]};
	assign ac5 = {16'd0, ac56_q[31:16]};
	assign ac6 = {16'd0, ac56_q[15:0]};
	assign b1  = sx16(b12_q[31:16]);
	assign b2  = sx16(b12_q[15:0]);
	assign mc  = sx16(mcmd_q[31:16]);
	assign md  = sx16(mcmd_q[15:0]);

	logic en;
	logic pipe_v;
	psc_out_t pipe_d;

	assign sample.ready = en;

	// stage 1: x1 of the temperature part
	logic        v_s1;
	logic [31:0] x1_s1;
	logic [18:0] up_s1;
	logic [31:0] tprod;
	assign tprod = ({16'd0, sample.data.raw_temperature} - ac6) * ac5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= 32'($signed(tprod) >>> 15);
			up_s1 <= sample.data.raw_pressure;
		end
	end

	// signed division mc<<11 / (x1 + md) as magnitudes
	logic [31:0] num1, den1, mnum1, mden1;
	assign num1  = mc << 11;
	assign den1  = x1_s1 + md;
	assign mnum1 = num1[31] ? 32'(0) - num1 : num1;
	assign mden1 = den1[31] ? 32'(0) - den1 : den1;

	logic        d1_v;
	logic [31:0] q1;
	logic [52:0] d1_side;
	psc_div #(.W(32), .SW(53)) u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s1),
		.num(mnum1), .den(mden1),
		.side_in({x1_s1, up_s1, num1[31] ^ den1[31], den1 == '0}),
		.out_v(d1_v), .quot(q1), .side_out(d1_side)
	);

	// stage 2: b6
	logic        v_s2, err_s2;
	logic [31:0] b6_s2;
	logic [18:0] up_s2;
	logic [31:0] x2t;
	assign x2t = d1_side[1] ? 32'(0) - q1 : q1;

	// stages 3..6
	logic        v_s3, err_s3, v_s4, err_s4, v_s5, err_s5, v_s6, err_s6;
	logic [31:0] sq_s3, m2_s3, m3_s3;
	logic [18:0] up_s3, up_s4, up_s5;
	logic [31:0] xa_s4, xb_s4, m2_s4, m3_s4;
	logic [31:0] b3_s5, x3_s5;
	logic [31:0] b4_s6, b7_s6;
	logic [31:0] sqp, p2, p3, p4a, p4b, b3sum, b3sh, x3sum, b4p, b7p;

	assign sqp   = b6_s2 * b6_s2;
	assign p2    = ac2 * b6_s2;
	assign p3    = ac3 * b6_s2;
	assign p4a   = b2 * sq_s3;
	assign p4b   = b1 * sq_s3;
	assign b3sum = (ac1 << 2) + xa_s4 + m2_s4;
	assign b3sh  = (b3sum << oss_q) + 32'd2;
	assign x3sum = m3_s4 + xb_s4 + 32'd2;
	assign b4p   = ac4 * (x3_s5 + B4Bias);
	assign b7p   = ({13'd0, up_s5} - b3_s5) * (B7Scale >> oss_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s2 <= d1_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b6_s2  <= d1_side[52:21] + x2t - B6Offset;
			up_s2  <= d1_side[20:2];
			err_s2 <= d1_side[0];

			sq_s3  <= 32'($signed(sqp) >>> 12);
			m2_s3  <= 32'($signed(p2) >>> 11);
			m3_s3  <= 32'($signed(p3) >>> 13);
			up_s3  <= up_s2;
			err_s3 <= err_s2;

			xa_s4  <= 32'($signed(p4a) >>> 11);
			xb_s4  <= 32'($signed(p4b) >>> 16);
			m2_s4  <= m2_s3;
			m3_s4  <= m3_s3;
			up_s4  <= up_s3;
			err_s4 <= err_s3;

			b3_s5  <= 32'($signed(b3sh) >>> 2);
			x3_s5  <= 32'($signed(x3sum) >>> 2);
			up_s5  <= up_s4;
			err_s5 <= err_s4;

			b4_s6  <= b4p >> 15;
			b7_s6  <= b7p;
			err_s6 <= err_s5;
		end
	end

	// unsigned division; large b7 divides first and doubles after
	logic        big6;
	logic        d2_v;
	logic [31:0] q2;
	logic [1:0]  d2_side;
	assign big6 = b7_s6 >= SignBit;

	psc_div #(.W(32), .SW(2)) u_div_p (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s6),
		.num(big6 ? b7_s6 : b7_s6 << 1), .den(b4_s6),
		.side_in({big6, err_s6 || b4_s6 == '0}),
		.out_v(d2_v), .quot(q2), .side_out(d2_side)
	);

	// stages 7..9: correction polynomial
	logic        v_s7, err_s7, v_s8, err_s8, v_s9;
	logic [31:0] p_s7, t2_s7, p_s8, ya_s8, yb_s8;
	psc_out_t    o_s9;
	logic [31:0] p7, t7, ya, yb, fin;
	assign p7  = d2_side[1] ? q2 << 1 : q2;
	assign t7  = 32'($signed(p7) >>> 8);
	assign ya  = t2_s7 * PolyC2;
	assign yb  = PolyC1 * p_s7;
	assign fin = ya_s8 + yb_s8 + PolyC0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s7 <= d2_v;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s7   <= p7;
			t2_s7  <= t7 * t7;
			err_s7 <= d2_side[0];

			p_s8   <= p_s7;
			ya_s8  <= 32'($signed(ya) >>> 16);
			yb_s8  <= 32'($signed(yb) >>> 16);
			err_s8 <= err_s7;

			o_s9.pressure_pa <= err_s8 ? '0 : $signed(p_s8 + 32'($signed(fin) >>> 4));
			o_s9.status      <= err_s8;
		end
	end

	assign pipe_v = v_s9;
	assign pipe_d = o_s9;

	psc_skid u_skid (
		.clk(clk), .arst_n(arst_n),
		.up_v(pipe_v), .up_d(pipe_d), .up_ready(en),
		.result(result)
	);

`ifndef SYNTH
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> v_s1)
		else $error("accepted item missing from first stage");
	a_stall_holds_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s9) && (!v_s9 || $stable(o_s9))))
		else $error("pipe tail changed while stalled");
	a_err_zero_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s9 && o_s9.status) |-> (o_s9.pressure_pa == '0))
		else $error("error item carries a pressure");
`endif
endmodule
`default_nettype wire
